// File: rtl/core/iff_pkg.sv
// iff_pkg: types, codes and constants shared by the integer field formatter
// used by iff_front, iff_queue, iff_back, integer_field_formatter and iff_checker
`default_nettype none

package iff_pkg;

  localparam logic [1:0] KIND_UDEC = 2'd0;
  localparam logic [1:0] KIND_SDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_PTR  = 2'd3;

  localparam int POINTER_DIGITS  = 8;
  localparam int MAX_FIELD_WIDTH = 63;

  // longest digit string: ten decimal digits for a 32-bit magnitude
  localparam int DIG_SLOTS = 10;
  localparam int DIG_IDX_W = $clog2(DIG_SLOTS);

  // ceil(2^35 / 10); floor(v * DIV10_RECIP / 2^35) is v / 10 for every 32-bit v
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h57; // 'a' - 10

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        pad_zero;
    logic [5:0]  field_width;
  } iff_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } iff_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic        hex;
    logic        pad_zero;
    logic [5:0]  width;
  } iff_job_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = CH_ZERO + {4'b0, d};
    end else begin
      g = CH_ALPHA + {4'b0, d};
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/iff_front.sv
// iff_front: input register that classifies each item (sign, magnitude, width)
// depends on iff_pkg
`default_nettype none

module iff_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire iff_pkg::iff_in_t  item,
  output logic                   job_valid,
  input  wire logic              job_ready,
  output iff_pkg::iff_job_t      job
);
  import iff_pkg::*;

  logic     full;
  iff_job_t held;
  iff_job_t classified;

  always_comb begin
    classified          = '0;
    classified.pad_zero = item.pad_zero;
    classified.hex      = (item.kind == KIND_HEX) || (item.kind == KIND_PTR);
    classified.neg      = (item.kind == KIND_SDEC) && item.value[31];
    classified.mag      = classified.neg ? (32'd0 - item.value) : item.value;
    if (item.kind == KIND_PTR) begin
      classified.width = 6'(POINTER_DIGITS);
    end else if (item.field_width > 6'(MAX_FIELD_WIDTH)) begin
      classified.width = 6'(MAX_FIELD_WIDTH);
    end else begin
      classified.width = item.field_width;
    end
  end

  assign item_ready = !full || job_ready;
  assign job_valid  = full;
  assign job        = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && item_ready) begin
      full <= 1'b1;
    end else if (job_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= classified;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/iff_queue.sv
// iff_queue: two-entry queue of classified items between front and back
// depends on iff_pkg
`default_nettype none

module iff_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire iff_pkg::iff_job_t  push_job,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output iff_pkg::iff_job_t       pop_job
);
  import iff_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  iff_job_t             slots [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     cnt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt != CNT_W'(QDEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/iff_back.sv
// iff_back: digit extraction (reciprocal multiply for decimal) and character emitter
// depends on iff_pkg
`default_nettype none

module iff_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire iff_pkg::iff_job_t  job,
  output logic                    glyph_valid,
  input  wire logic               glyph_ready,
  output iff_pkg::iff_out_t       glyph
);
  import iff_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIGITS = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]           state;
  logic [31:0]          mag;
  logic                 neg;
  logic                 hex;
  logic                 pad_zero;
  logic [5:0]           width;
  logic [DIG_IDX_W-1:0] nd;
  logic [3:0]           dig [DIG_SLOTS];
  logic                 phase;
  logic [63:0]          prod;
  logic [5:0]           pad_cnt;
  logic                 sign_pend;
  logic [DIG_IDX_W-1:0] idx;

  logic [28:0]          quo;
  logic [31:0]          quo_x10;
  logic [31:0]          rem;
  logic [3:0]           digit;
  logic [31:0]          mag_next;
  logic                 digit_done;
  logic [DIG_IDX_W-1:0] nd_next;
  logic [7:0]           pad_raw;
  logic                 emit_fire;
  iff_out_t             emit_glyph;

  assign job_ready = (state == ST_IDLE);

  // decimal: after the multiply phase, turns the registered product into quotient and remainder
  always_comb begin
    quo     = prod[63:DIV10_SHIFT];
    quo_x10 = 32'({quo, 3'b000}) + 32'({quo, 1'b0});
    rem     = mag - quo_x10;
    if (hex) begin
      digit    = mag[3:0];
      mag_next = {4'b0, mag[31:4]};
    end else begin
      digit    = rem[3:0];
      mag_next = 32'(quo);
    end
    digit_done = hex || phase;
    nd_next    = nd + 1'b1;
    pad_raw    = {2'b00, width} - {7'b0, neg} - 8'(nd_next);
  end

  assign emit_fire = (state == ST_EMIT) && (!glyph_valid || glyph_ready);

  always_comb begin
    emit_glyph = '0;
    if (sign_pend) begin
      emit_glyph.character = CH_MINUS;
    end else if (pad_cnt != '0) begin
      emit_glyph.character = pad_zero ? CH_ZERO : CH_SPACE;
    end else begin
      emit_glyph.character = hex_glyph(dig[idx]);
      emit_glyph.last      = (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      glyph_valid <= 1'b0;
      phase       <= 1'b0;
      nd          <= '0;
      sign_pend   <= 1'b0;
      pad_cnt     <= '0;
      idx         <= '0;
    end else begin
      if (emit_fire) begin
        glyph_valid <= 1'b1;
      end else if (glyph_ready) begin
        glyph_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_DIGITS;
            phase <= 1'b0;
            nd    <= '0;
          end
        end
        ST_DIGITS: begin
          phase <= !digit_done;
          if (digit_done) begin
            nd <= nd_next;
            if (mag_next == '0) begin
              state     <= ST_EMIT;
              idx       <= nd;
              sign_pend <= neg;
              pad_cnt   <= pad_raw[7] ? 6'd0 : pad_raw[5:0];
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else if (pad_cnt != '0) begin
              pad_cnt <= pad_cnt - 1'b1;
            end else if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      mag      <= job.mag;
      neg      <= job.neg;
      hex      <= job.hex;
      pad_zero <= job.pad_zero;
      width    <= job.width;
    end else if (state == ST_DIGITS) begin
      if (!digit_done) begin
        prod <= 64'(mag) * 64'(DIV10_RECIP);
      end else begin
        mag     <= mag_next;
        dig[nd] <= digit;
      end
    end
    if (emit_fire) begin
      glyph <= emit_glyph;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/integer_field_formatter.sv
// flow: the input register classifies each item, the back end takes it from the queue,
// then extracts hex digits directly or decimal digits by a multiply, then a remainder
// step, then emits one character per cycle while glyph_ready does not stall the output
// the back end accepts no new item until the last character is out; the front
// and the two-entry queue keep accepting items while it works, until both are full
// reset: synchronous rst empties front, queue and output; no clearing pass
`default_nettype none

module integer_field_formatter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire iff_pkg::iff_in_t  item,
  output logic                   glyph_valid,
  input  wire logic              glyph_ready,
  output iff_pkg::iff_out_t      glyph
);
  import iff_pkg::*;

  logic     f_valid;
  logic     f_ready;
  iff_job_t f_job;
  logic     q_valid;
  logic     q_ready;
  iff_job_t q_job;

  iff_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job        (f_job)
  );

  iff_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  iff_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job         (q_job),
    .glyph_valid (glyph_valid),
    .glyph_ready (glyph_ready),
    .glyph       (glyph)
  );

endmodule

`default_nettype wire

// File: rtl/core/iff_checker.sv
// iff_checker: port-level checks on the formatter's output beats, bound to the top
// depends on iff_pkg and integer_field_formatter
`default_nettype none

module iff_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              glyph_valid,
  input wire logic              glyph_ready,
  input wire iff_pkg::iff_out_t glyph
);
  import iff_pkg::*;

  logic is_digit;
  assign is_digit = (glyph.character >= 8'h30 && glyph.character <= 8'h39) ||
                    (glyph.character >= 8'h61 && glyph.character <= 8'h66);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && !glyph_ready |=> glyph_valid && $stable(glyph))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !glyph_valid)
    else $error("output valid after reset");

  // the field always ends on a digit
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && glyph.last |-> is_digit)
    else $error("last beat is not a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && glyph.character == CH_MINUS |-> !glyph.last)
    else $error("sign marked as last");

  // every beat is a sign, a pad or a digit
  a_charset: assert property (@(posedge clk) disable iff (rst)
    glyph_valid |-> is_digit || glyph.character == CH_MINUS ||
                    glyph.character == CH_SPACE)
    else $error("unexpected character");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);

`default_nettype wire
